// ----- rtl/ltl_pkg.sv -----
// Shared constants for the Liberty token lexer: codes, characters and default widths.
package ltl_pkg;

  localparam int DEFAULT_LINE_BITS   = 20;
  localparam int DEFAULT_COLUMN_BITS = 16;

  localparam logic EV_TEXT = 1'b0;
  localparam logic EV_DONE = 1'b1;

  localparam logic [2:0] CLS_INT   = 3'd0;
  localparam logic [2:0] CLS_FLOAT = 3'd1;
  localparam logic [2:0] CLS_STR   = 3'd2;
  localparam logic [2:0] CLS_NL    = 3'd3;
  localparam logic [2:0] CLS_CHAR  = 3'd4;
  localparam logic [2:0] CLS_ERR   = 3'd5;
  localparam logic [2:0] CLS_END   = 3'd6;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_DOT_DIGIT   = 3'd1;
  localparam logic [2:0] ERR_EXPONENT    = 3'd2;
  localparam logic [2:0] ERR_NL_QUOTE    = 3'd3;
  localparam logic [2:0] ERR_END_QUOTE   = 3'd4;
  localparam logic [2:0] ERR_END_COMMENT = 3'd5;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

endpackage

// ----- rtl/ltl_byte_if.sv -----
// Source byte channel of the Liberty token lexer.
interface ltl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ----- rtl/ltl_token_if.sv -----
// Result channel of the Liberty token lexer: text bytes and token-complete words.
interface ltl_token_if
  import ltl_pkg::*;
#(
  parameter int LINE_BITS   = DEFAULT_LINE_BITS,
  parameter int COLUMN_BITS = DEFAULT_COLUMN_BITS
);
  logic                   valid;
  logic                   ready;
  logic                   event_kind;
  logic [2:0]             token_class;
  logic [7:0]             text_byte;
  logic [2:0]             error_code;
  logic [LINE_BITS-1:0]   start_line;
  logic [COLUMN_BITS-1:0] start_column;
  logic                   last_of_run;

  modport source (
    output valid, output event_kind, output token_class, output text_byte,
    output error_code, output start_line, output start_column, output last_of_run,
    input ready
  );
  modport sink (
    input valid, input event_kind, input token_class, input text_byte,
    input error_code, input start_line, input start_column, input last_of_run,
    output ready
  );
endinterface

// ----- rtl/liberty_token_lexer.sv -----
// Streaming Liberty lexer: one source byte per word in, token text and token ends out.
//
//   channel       role   words carried
//   byte_stream   sink   in_byte, end_of_input
//   token_stream  source event_kind, token_class, text_byte, error_code,
//                        start_line, start_column, last_of_run
//
// One byte is taken per cycle while the byte side is ready; its results land in a three-entry result queue
// in the same edge. A byte that both ends a token and starts another gives two
// words, which can stall the byte side; the queue depth sets that.
// Reset clears the queue, the lexer state and the line and column counters.
// A stalled result side stops the byte side once two words are queued.
module liberty_token_lexer
  import ltl_pkg::*;
#(
  parameter int LINE_BITS   = DEFAULT_LINE_BITS,
  parameter int COLUMN_BITS = DEFAULT_COLUMN_BITS
) (
  input logic       clk,
  input logic       rst,
  ltl_byte_if.sink  byte_stream,
  ltl_token_if.source token_stream
);

  typedef enum logic [12:0] {
    S_INIT = 13'b0000000000001,
    S_BS   = 13'b0000000000010,
    S_NUM1 = 13'b0000000000100,
    S_DOT  = 13'b0000000001000,
    S_NUM2 = 13'b0000000010000,
    S_NUM3 = 13'b0000000100000,
    S_NUM4 = 13'b0000001000000,
    S_ID   = 13'b0000010000000,
    S_DQ   = 13'b0000100000000,
    S_COM1 = 13'b0001000000000,
    S_COM2 = 13'b0010000000000,
    S_COM3 = 13'b0100000000000,
    S_COM4 = 13'b1000000000000
  } state_t;

  typedef struct packed {
    state_t     nxt;
    logic       emit;
    logic       kind;
    logic [2:0] cls;
    logic [7:0] text;
    logic [2:0] err;
    logic       newline;
    logic       again;
  } pass_t;

  typedef struct packed {
    logic                   event_kind;
    logic [2:0]             token_class;
    logic [7:0]             text_byte;
    logic [2:0]             error_code;
    logic [LINE_BITS-1:0]   start_line;
    logic [COLUMN_BITS-1:0] start_column;
    logic                   last_of_run;
  } result_t;

  function automatic pass_t lex_pass(state_t st, logic [7:0] ch, logic eof);
    pass_t p;
    logic  digit;
    logic  alpha;
    logic  nl;
    logic  is_ch;
    is_ch = !eof;
    digit = is_ch && ch >= CH_0 && ch <= CH_9;
    alpha = is_ch && ((ch >= CH_LO_A && ch <= CH_LO_Z) || (ch >= CH_UP_A && ch <= CH_UP_Z) ||
                      ch == CH_UNDER);
    nl    = is_ch && ch == CH_LF;
    p.nxt     = st;
    p.emit    = 1'b0;
    p.kind    = EV_TEXT;
    p.cls     = CLS_INT;
    p.text    = 8'h00;
    p.err     = ERR_NONE;
    p.newline = 1'b0;
    p.again   = 1'b0;
    unique case (st)
      S_INIT: begin
        if (digit) begin
          p.emit = 1'b1; p.text = ch; p.nxt = S_NUM1;
        end else if (alpha) begin
          p.emit = 1'b1; p.text = ch; p.nxt = S_ID;
        end else if (is_ch && ch == CH_DOT) begin
          p.emit = 1'b1; p.text = ch; p.nxt = S_DOT;
        end else if (eof) begin
          p.emit = 1'b1; p.kind = EV_DONE; p.cls = CLS_END;
        end else if (ch == CH_SPACE || ch == CH_TAB) begin
          p.nxt = S_INIT;
        end else if (nl) begin
          p.emit = 1'b1; p.kind = EV_DONE; p.cls = CLS_NL; p.newline = 1'b1;
        end else if (ch == CH_QUOTE) begin
          p.nxt = S_DQ;
        end else if (ch == CH_BSLASH) begin
          p.nxt = S_BS;
        end else if (ch == CH_SLASH) begin
          p.nxt = S_COM1;
        end else begin
          p.emit = 1'b1; p.kind = EV_DONE; p.cls = CLS_CHAR; p.text = ch;
        end
      end
      S_BS: begin
        p.nxt = S_INIT;
        if (nl) begin
          p.newline = 1'b1;
        end else begin
          p.again = 1'b1;
        end
      end
      S_NUM1: begin
        if (digit) begin
          p.emit = 1'b1; p.text = ch;
        end else if (is_ch && ch == CH_DOT) begin
          p.emit = 1'b1; p.text = ch; p.nxt = S_DOT;
        end else begin
          p.emit = 1'b1; p.kind = EV_DONE; p.cls = CLS_INT; p.nxt = S_INIT; p.again = 1'b1;
        end
      end
      S_DOT: begin
        if (digit) begin
          p.emit = 1'b1; p.text = ch; p.nxt = S_NUM2;
        end else begin
          p.emit = 1'b1; p.kind = EV_DONE; p.cls = CLS_ERR; p.err = ERR_DOT_DIGIT;
          p.nxt = S_INIT;
        end
      end
      S_NUM2: begin
        if (digit) begin
          p.emit = 1'b1; p.text = ch;
        end else if (is_ch && (ch == CH_LO_E || ch == CH_UP_E)) begin
          p.emit = 1'b1; p.text = ch; p.nxt = S_NUM3;
        end else begin
          p.emit = 1'b1; p.kind = EV_DONE; p.cls = CLS_FLOAT; p.nxt = S_INIT; p.again = 1'b1;
        end
      end
      S_NUM3: begin
        if (digit || (is_ch && (ch == CH_PLUS || ch == CH_MINUS))) begin
          p.emit = 1'b1; p.text = ch; p.nxt = S_NUM4;
        end else begin
          p.emit = 1'b1; p.kind = EV_DONE; p.cls = CLS_ERR; p.err = ERR_EXPONENT;
          p.nxt = S_INIT;
        end
      end
      S_NUM4: begin
        if (digit) begin
          p.emit = 1'b1; p.text = ch;
        end else begin
          p.emit = 1'b1; p.kind = EV_DONE; p.cls = CLS_FLOAT; p.nxt = S_INIT; p.again = 1'b1;
        end
      end
      S_ID: begin
        if (digit || alpha) begin
          p.emit = 1'b1; p.text = ch;
        end else begin
          p.emit = 1'b1; p.kind = EV_DONE; p.cls = CLS_STR; p.nxt = S_INIT; p.again = 1'b1;
        end
      end
      S_DQ: begin
        p.emit = 1'b1;
        if (is_ch && ch == CH_QUOTE) begin
          p.kind = EV_DONE; p.cls = CLS_STR; p.nxt = S_INIT;
        end else if (nl) begin
          p.kind = EV_DONE; p.cls = CLS_ERR; p.err = ERR_NL_QUOTE; p.nxt = S_INIT;
        end else if (eof) begin
          p.kind = EV_DONE; p.cls = CLS_ERR; p.err = ERR_END_QUOTE; p.nxt = S_INIT;
        end else begin
          p.text = ch;
        end
      end
      S_COM1: begin
        if (is_ch && ch == CH_SLASH) begin
          p.nxt = S_COM2;
        end else if (is_ch && ch == CH_STAR) begin
          p.nxt = S_COM3;
        end else begin
          p.emit = 1'b1; p.kind = EV_DONE; p.cls = CLS_CHAR; p.text = CH_SLASH;
          p.nxt = S_INIT; p.again = 1'b1;
        end
      end
      S_COM2: begin
        if (nl) begin
          p.newline = 1'b1; p.nxt = S_INIT;
        end else if (eof) begin
          p.emit = 1'b1; p.kind = EV_DONE; p.cls = CLS_END; p.nxt = S_INIT;
        end
      end
      S_COM3: begin
        if (eof) begin
          p.emit = 1'b1; p.kind = EV_DONE; p.cls = CLS_ERR; p.err = ERR_END_COMMENT;
          p.nxt = S_INIT;
        end else if (ch == CH_STAR) begin
          p.nxt = S_COM4;
        end else if (nl) begin
          p.newline = 1'b1;
        end
      end
      S_COM4: begin
        if (eof) begin
          p.emit = 1'b1; p.kind = EV_DONE; p.cls = CLS_ERR; p.err = ERR_END_COMMENT;
          p.nxt = S_INIT;
        end else if (ch == CH_SLASH) begin
          p.nxt = S_INIT;
        end else if (ch != CH_STAR) begin
          p.newline = nl;
          p.nxt = S_COM3;
        end
      end
      default: begin
        p.nxt = S_INIT; p.again = 1'b1;
      end
    endcase
    return p;
  endfunction

  state_t                 lex_state;
  state_t                 lex_state_next;
  logic                   cr_pending;
  logic                   cr_pending_next;
  logic [LINE_BITS-1:0]   line_count;
  logic [LINE_BITS-1:0]   line_count_next;
  logic [COLUMN_BITS-1:0] column_count;
  logic [COLUMN_BITS-1:0] column_count_next;
  logic [LINE_BITS-1:0]   token_line;
  logic [LINE_BITS-1:0]   token_line_next;
  logic [COLUMN_BITS-1:0] token_column;
  logic [COLUMN_BITS-1:0] token_column_next;

  result_t    queue [3];
  result_t    queue_next [3];
  logic [1:0] count;
  logic [1:0] count_next;

  logic                   accept;
  logic                   pop;
  logic                   eof;
  logic [7:0]             ch;
  logic                   dropped;
  logic                   step;
  logic [COLUMN_BITS-1:0] column_inc;
  logic [LINE_BITS-1:0]   line_inc;
  pass_t                  p1;
  pass_t                  p2;
  logic                   use2;
  logic                   newline;
  logic                   push_first;
  logic                   push_second;
  result_t                res_a;
  result_t                res_b;
  result_t                res_first;
  logic [1:0]             cnt_pop;
  logic [1:0]             cnt_first;

  assign accept = byte_stream.valid && byte_stream.ready;
  assign pop    = token_stream.valid && token_stream.ready;
  assign byte_stream.ready = (count <= 2'd1);

  assign eof     = byte_stream.end_of_input;
  assign ch      = (byte_stream.in_byte == CH_CR) ? CH_LF : byte_stream.in_byte;
  assign dropped = !eof && byte_stream.in_byte == CH_LF && cr_pending;
  assign step    = accept && !dropped;

  assign column_inc = (column_count == '1) ? column_count : column_count + COLUMN_BITS'(1);
  assign line_inc   = (line_count == '1) ? line_count : line_count + LINE_BITS'(1);

  assign p1   = lex_pass(lex_state, ch, eof);
  assign p2   = lex_pass(S_INIT, ch, eof);
  assign use2 = p1.again;
  assign newline = p1.newline || (use2 && p2.newline);

  always_comb begin
    res_a.event_kind   = p1.kind;
    res_a.token_class  = p1.cls;
    res_a.text_byte    = p1.text;
    res_a.error_code   = p1.err;
    res_a.start_line   = (lex_state == S_INIT) ? line_count : token_line;
    res_a.start_column = (lex_state == S_INIT) ? column_inc : token_column;
    res_a.last_of_run  = !(use2 && p2.emit);
    res_b.event_kind   = p2.kind;
    res_b.token_class  = p2.cls;
    res_b.text_byte    = p2.text;
    res_b.error_code   = p2.err;
    res_b.start_line   = line_count;
    res_b.start_column = column_inc;
    res_b.last_of_run  = 1'b1;
  end

  assign res_first   = p1.emit ? res_a : res_b;
  assign push_first  = step && (p1.emit || (use2 && p2.emit));
  assign push_second = step && p1.emit && use2 && p2.emit;

  always_comb begin
    lex_state_next    = lex_state;
    cr_pending_next   = cr_pending;
    line_count_next   = line_count;
    column_count_next = column_count;
    token_line_next   = token_line;
    token_column_next = token_column;
    if (accept && !eof) begin
      cr_pending_next = (byte_stream.in_byte == CH_CR);
    end
    if (step) begin
      lex_state_next    = use2 ? p2.nxt : p1.nxt;
      line_count_next   = newline ? line_inc : line_count;
      column_count_next = newline ? '0 : column_inc;
      if (use2 || lex_state == S_INIT) begin
        token_line_next   = line_count;
        token_column_next = column_inc;
      end
    end
  end

  always_comb begin
    queue_next = queue;
    cnt_pop    = count;
    if (pop) begin
      queue_next[0] = queue[1];
      queue_next[1] = queue[2];
      cnt_pop       = count - 2'd1;
    end
    for (int i = 0; i < 3; i++) begin
      if (push_first && 2'(i) == cnt_pop) begin
        queue_next[i] = res_first;
      end
    end
    cnt_first = cnt_pop + 2'(push_first);
    for (int i = 0; i < 3; i++) begin
      if (push_second && 2'(i) == cnt_first) begin
        queue_next[i] = res_b;
      end
    end
    count_next = cnt_first + 2'(push_second);
  end

  always_ff @(posedge clk) begin
    queue <= queue_next;
    if (rst) begin
      lex_state    <= S_INIT;
      cr_pending   <= 1'b0;
      line_count   <= LINE_BITS'(1);
      column_count <= '0;
      token_line   <= LINE_BITS'(1);
      token_column <= '0;
      count        <= 2'd0;
    end else begin
      lex_state    <= lex_state_next;
      cr_pending   <= cr_pending_next;
      line_count   <= line_count_next;
      column_count <= column_count_next;
      token_line   <= token_line_next;
      token_column <= token_column_next;
      count        <= count_next;
    end
  end

  assign token_stream.valid        = (count != 2'd0);
  assign token_stream.event_kind   = queue[0].event_kind;
  assign token_stream.token_class  = queue[0].token_class;
  assign token_stream.text_byte    = queue[0].text_byte;
  assign token_stream.error_code   = queue[0].error_code;
  assign token_stream.start_line   = queue[0].start_line;
  assign token_stream.start_column = queue[0].start_column;
  assign token_stream.last_of_run  = queue[0].last_of_run;

endmodule

// ----- rtl/ltl_checker.sv -----
// Port-level checks for the Liberty token lexer, bound to its top level.
module ltl_checker
  import ltl_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       event_kind,
  input logic [2:0] token_class,
  input logic [7:0] text_byte,
  input logic [2:0] error_code
);

  // A word that waits on the result side keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({event_kind, token_class, text_byte,
                                                      error_code}))
    else $error("result word changed while stalled");

  // Error codes appear exactly on error tokens.
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((error_code != ERR_NONE) == (event_kind == EV_DONE && token_class == CLS_ERR)))
    else $error("error code does not match token class");

  // Text byte words carry no class.
  a_text_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_TEXT |-> token_class == CLS_INT)
    else $error("text byte word with a token class");

  // Right after reset the result side is empty and bytes are taken.
  a_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid && in_ready)
    else $error("lexer not empty after reset");

endmodule

bind liberty_token_lexer ltl_checker u_ltl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (byte_stream.ready),
  .out_valid   (token_stream.valid),
  .out_ready   (token_stream.ready),
  .event_kind  (token_stream.event_kind),
  .token_class (token_stream.token_class),
  .text_byte   (token_stream.text_byte),
  .error_code  (token_stream.error_code)
);
